[design/ssf_pkg.sv]
// Shared types, constants and helpers for the substring search unit.
package ssf_pkg;

  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 64;
  localparam int NUM_WORDS       = 4;
  localparam int WORD_SEL_W      = 2;
  localparam int PATTERN_BYTES   = 32;
  localparam int PAT_IDX_W       = 5;
  localparam int LEN_W           = 6;
  localparam int POS_W           = 16;
  localparam int CFG_INDEX_W     = 3;
  localparam int DEF_MAX_PATTERN = 32;
  localparam int DEF_MAX_TEXT    = 65536;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAT_LO      = 3'd0,
    REG_PAT_MID_LO  = 3'd1,
    REG_PAT_MID_HI  = 3'd2,
    REG_PAT_HI      = 3'd3,
    REG_PAT_LEN     = 3'd4,
    REG_IGNORE_CASE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_start;
  } out_item_t;

  typedef struct packed {
    logic             len_zero;
    logic             len_ok;
    logic [LEN_W-1:0] len;
    logic             ignore_case;
  } pat_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic en);
    if (en && (b inside {[8'h61:8'h7A]})) begin
      return b - 8'h20;
    end
    return b;
  endfunction

endpackage

[design/ssf_cfg_regs.sv]
// Configuration registers and the registered, right-aligned copy of the pattern.
module ssf_cfg_regs #(
  parameter int MAX_PATTERN = ssf_pkg::DEF_MAX_PATTERN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ssf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssf_pkg::WORD_W-1:0]      cfg_wdata,
  output ssf_pkg::pat_ctrl_t              ctrl,
  output logic [ssf_pkg::BYTE_W-1:0]      pat_aligned [MAX_PATTERN],
  output logic [MAX_PATTERN-1:0]          pat_mask
);
  import ssf_pkg::*;

  logic [WORD_W-1:0] pat_words [NUM_WORDS];
  logic [LEN_W-1:0]  pat_len;
  logic              ign;

  logic [BYTE_W-1:0]      pat_bytes [PATTERN_BYTES];
  logic [BYTE_W-1:0]      aligned_next [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] mask_next;
  logic [LEN_W-1:0]       src_idx [MAX_PATTERN];
  pat_ctrl_t              ctrl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        pat_words[w] <= '0;
      end
      pat_len <= '0;
      ign     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LO, REG_PAT_MID_LO, REG_PAT_MID_HI, REG_PAT_HI: begin
          pat_words[cfg_index[WORD_SEL_W-1:0]] <= cfg_wdata;
        end
        REG_PAT_LEN:     pat_len <= cfg_wdata[LEN_W-1:0];
        REG_IGNORE_CASE: ign     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      pat_bytes[k] = pat_words[WORD_SEL_W'(k >> 3)][(k & 7) * BYTE_W +: BYTE_W];
    end
    for (int j = 0; j < MAX_PATTERN; j++) begin
      src_idx[j]      = pat_len - LEN_W'(1) - LEN_W'(j);
      mask_next[j]    = LEN_W'(j) < pat_len;
      aligned_next[j] = fold_byte(pat_bytes[src_idx[j][PAT_IDX_W-1:0]], ign);
    end
    ctrl_next.len_zero    = (pat_len == '0);
    ctrl_next.len_ok      = (pat_len != '0) && (pat_len <= LEN_W'(MAX_PATTERN));
    ctrl_next.len         = pat_len;
    ctrl_next.ignore_case = ign;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_mask <= '0;
      ctrl     <= '{len_zero: 1'b1, len_ok: 1'b0, len: '0, ignore_case: 1'b0};
    end else begin
      pat_mask <= mask_next;
      ctrl     <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pat_aligned[j] <= aligned_next[j];
    end
  end

endmodule

[design/ssf_match_core.sv]
// Input register, text window and position state, parallel compare and result register.
module ssf_match_core #(
  parameter int MAX_PATTERN = ssf_pkg::DEF_MAX_PATTERN,
  parameter int MAX_TEXT    = ssf_pkg::DEF_MAX_TEXT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ssf_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ssf_pkg::out_item_t         out_data,
  input  ssf_pkg::pat_ctrl_t         ctrl,
  input  logic [ssf_pkg::BYTE_W-1:0] pat_aligned [MAX_PATTERN],
  input  logic [MAX_PATTERN-1:0]     pat_mask
);
  import ssf_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT - 1);

  logic     s1_valid;
  in_item_t s1_item;
  logic     advance;

  logic [BYTE_W-1:0] window [MAX_PATTERN];
  logic [POS_W-1:0]  pos;
  logic              zero_seen;
  logic [POS_W-1:0]  first_zero;
  logic              done;

  logic [BYTE_W-1:0]      win_next [MAX_PATTERN];
  logic                   zero_seen_next;
  logic [POS_W-1:0]       first_zero_next;
  logic [POS_W-1:0]       pos_next;
  logic [POS_W:0]         end_count;
  logic [POS_W:0]         start_wide;
  logic [POS_W-1:0]       start;
  logic                   reach;
  logic                   blocked;
  logic [MAX_PATTERN-1:0] eq;
  logic                   hit;
  logic                   emit_found;
  logic                   emit_none;
  out_item_t              result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_comb begin
    win_next[0] = s1_item.text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_next[k] = window[k-1];
    end
    zero_seen_next  = zero_seen || (s1_item.text_byte == '0);
    first_zero_next = ((s1_item.text_byte == '0) && !zero_seen) ? pos : first_zero;
    pos_next        = (pos < POS_MAX) ? pos + POS_W'(1) : pos;

    end_count  = {1'b0, pos} + (POS_W+1)'(1);
    reach      = end_count >= (POS_W+1)'(ctrl.len);
    start_wide = end_count - (POS_W+1)'(ctrl.len);
    start      = start_wide[POS_W-1:0];
    blocked    = zero_seen_next && (first_zero_next <= start);

    for (int j = 0; j < MAX_PATTERN; j++) begin
      eq[j] = !pat_mask[j] ||
              (fold_byte(win_next[j], ctrl.ignore_case) == pat_aligned[j]);
    end
    hit = ctrl.len_ok && reach && !blocked && (&eq);

    emit_found = !done && (ctrl.len_zero || hit);
    emit_none  = !done && !emit_found && s1_item.is_last;

    result.found       = emit_found;
    result.match_start = (emit_found && !ctrl.len_zero) ? start : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      zero_seen  <= 1'b0;
      first_zero <= '0;
      done       <= 1'b0;
    end else if (advance) begin
      if (s1_item.is_last) begin
        pos        <= '0;
        zero_seen  <= 1'b0;
        first_zero <= '0;
        done       <= 1'b0;
      end else begin
        pos        <= pos_next;
        zero_seen  <= zero_seen_next;
        first_zero <= first_zero_next;
        done       <= done || emit_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window[k] <= win_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (emit_found || emit_none)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (emit_found || emit_none)) begin
      out_data <= result;
    end
  end

endmodule

[design/substring_search_with_case_fold_unit.sv]
// Top level of the streaming substring search unit with optional ASCII case folding.
//
// Text enters one byte per transfer on the in channel; is_last marks the final
// byte of a text and returns the position counter and match state to a new text.
// Each text yields at most one transfer on the out channel: the start position of
// the first match, or found low when the text ends without one.
// A byte is registered in the input register at its transfer, compared against the
// whole pattern window there, and its result is then held in the output register.
// One byte can be taken every cycle while the output register is empty or its result
// is taken; the rate is set by the combinational window compare between the input and
// output registers. The output register parts the channels: while a result waits, one
// more byte is held in the input register and further bytes wait until the result is
// taken. The user is to write registers through the write port only while no byte is
// in flight; the block does not enforce it. A byte may be transferred in the cycle
// after a write. Reset clears the registers, the text state and both pipeline stages;
// no result is pending after reset.
module substring_search_with_case_fold_unit #(
  parameter int MAX_PATTERN = ssf_pkg::DEF_MAX_PATTERN,
  parameter int MAX_TEXT    = ssf_pkg::DEF_MAX_TEXT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ssf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ssf_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [ssf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssf_pkg::WORD_W-1:0]      cfg_wdata
);
  import ssf_pkg::*;

  pat_ctrl_t              ctrl;
  logic [BYTE_W-1:0]      pat_aligned [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pat_mask;

  ssf_cfg_regs #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .ctrl       (ctrl),
    .pat_aligned(pat_aligned),
    .pat_mask   (pat_mask)
  );

  ssf_match_core #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .ctrl       (ctrl),
    .pat_aligned(pat_aligned),
    .pat_mask   (pat_mask)
  );

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_not_found_zero_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.match_start == '0))
    else $error("not-found result carries a nonzero start position");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending right after reset");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the streaming substring search unit with case folding.
module tb_top;
  import ssf_pkg::*;

  localparam int TEXT_LIMIT = DEF_MAX_TEXT;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_wdata = '0;

  in_item_t text_q[$];
  out_item_t result_q[$];
  out_item_t want;
  int errors = 0;
  int gap_pct = 34;
  int stall_pct = 34;

  logic [BYTE_W-1:0] pat_bytes[PATTERN_BYTES];
  logic [LEN_W-1:0] pat_len = '0;
  logic fold_en = 1'b0;
  logic [BYTE_W-1:0] window[PATTERN_BYTES];
  int text_pos;
  bit zero_seen;
  int zero_pos;
  bit reported;

  substring_search_with_case_fold_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] b);
    if (fold_en && b >= 8'h61 && b <= 8'h7A) begin
      return b - 8'h20;
    end
    return b;
  endfunction

  task automatic clear_text();
    int k;
    for (k = 0; k < PATTERN_BYTES; k++) begin
      window[k] = '0;
    end
    text_pos = 0;
    zero_seen = 1'b0;
    zero_pos = 0;
    reported = 1'b0;
  endtask

  task automatic search_step(input in_item_t it);
    out_item_t res;
    bit hit;
    bit ok;
    int start;
    int len;
    int k;
    for (k = PATTERN_BYTES - 1; k > 0; k--) begin
      window[k] = window[k-1];
    end
    window[0] = it.text_byte;
    if (it.text_byte == 8'h00 && !zero_seen) begin
      zero_seen = 1'b1;
      zero_pos = text_pos;
    end
    hit = 1'b0;
    len = int'(pat_len);
    res = '0;
    if (!reported) begin
      if (len == 0) begin
        hit = 1'b1;
        res.found = 1'b1;
        reported = 1'b1;
      end else if (len <= PATTERN_BYTES && text_pos + 1 >= len) begin
        start = text_pos + 1 - len;
        ok = !(zero_seen && zero_pos <= start);
        for (k = 0; k < len; k++) begin
          if (upcase(window[len-1-k]) != upcase(pat_bytes[k])) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          hit = 1'b1;
          res.found = 1'b1;
          res.match_start = start[POS_W-1:0];
          reported = 1'b1;
        end
      end
      if (!hit && it.is_last) begin
        hit = 1'b1;
      end
    end
    if (hit) begin
      result_q.push_back(res);
    end
    if (text_pos < TEXT_LIMIT - 1) begin
      text_pos++;
    end
    if (it.is_last) begin
      clear_text();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        search_step(in_data);
      end
      if (!in_valid || in_ready) begin
        if (text_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_data <= text_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got found=%0b match_start=%0d",
                   $time, out_data.found, out_data.match_start);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_data.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_data.found);
            errors++;
          end
          if (out_data.match_start !== want.match_start) begin
            $display("%0t: match_start mismatch, expected %0d, got %0d",
                     $time, want.match_start, out_data.match_start);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
    int j;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx <= REG_PAT_HI) begin
      for (j = 0; j < 8; j++) begin
        pat_bytes[int'(idx) * 8 + j] = val[8*j +: 8];
      end
    end else if (idx == REG_PAT_LEN) begin
      pat_len = val[LEN_W-1:0];
    end else if (idx == REG_IGNORE_CASE) begin
      fold_en = val[0];
    end
  endtask

  task automatic set_search(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                            input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                            input logic [LEN_W-1:0] len, input logic fold);
    write_reg(REG_PAT_LO, w0);
    write_reg(REG_PAT_MID_LO, w1);
    write_reg(REG_PAT_MID_HI, w2);
    write_reg(REG_PAT_HI, w3);
    write_reg(REG_PAT_LEN, WORD_W'(len));
    write_reg(REG_IGNORE_CASE, WORD_W'(fold));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    in_item_t it;
    it.text_byte = b;
    it.is_last = last;
    text_q.push_back(it);
  endtask

  // A '#' in the string stands for a zero byte; the final character ends the text.
  task automatic queue_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) begin
      push_byte((s[k] == "#") ? 8'h00 : s[k], k == s.len() - 1);
    end
  endtask

  task automatic drain();
    while (text_q.size() > 0 || in_valid || result_q.size() > 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(15))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      3: return 8'h42;
      4: return 8'h7A;
      5: return 8'h5A;
      6: return 8'h40;
      7: return 8'h5B;
      8: return 8'h60;
      9: return 8'h7B;
      10: return 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] maybe_flip(input logic [BYTE_W-1:0] b);
    if (((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) &&
        $urandom_range(2) == 0) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  initial begin : stimulus
    logic [BYTE_W-1:0] pb[PATTERN_BYTES];
    logic [WORD_W-1:0] w[NUM_WORDS];
    logic [LEN_W-1:0] len;
    logic fold;
    int random_items;
    int phase;
    int ntexts;
    int t;
    int k;
    int r;
    int n;
    bit noise;
    int idx;
    for (k = 0; k < PATTERN_BYTES; k++) begin
      pat_bytes[k] = '0;
    end
    clear_text();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    queue_text("Q");
    drain();

    for (idx = REG_IGNORE_CASE + 1; idx < (1 << CFG_INDEX_W); idx++) begin
      write_reg(CFG_INDEX_W'(idx), '1);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    queue_text("z");
    drain();

    set_search('1, '1, '1, '1, '1, 1'b1);
    queue_text("xyz");
    drain();

    set_search(64'h6241, '0, '0, '0, 6'd2, 1'b0);
    queue_text("abAb");
    queue_text("AB");
    queue_text("A");
    queue_text("#Ab");
    drain();

    set_search(64'h6241, '0, '0, '0, 6'd2, 1'b1);
    queue_text("xaB");
    drain();

    set_search(64'h0041, '0, '0, '0, 6'd2, 1'b0);
    queue_text("A#");
    drain();

    // A longer run of filler bytes ahead of the match.
    set_search(64'h44434241, '0, '0, '0, 6'd4, 1'b0);
    for (k = 0; k < 40; k++) begin
      push_byte(8'h78, 1'b0);
    end
    queue_text("ABCD");
    queue_text("ABCD");
    drain();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      gap_pct = (phase >= 6 && phase < 10) ? 0 : 34;
      stall_pct = gap_pct;
      r = $urandom_range(99);
      if (r < 5) begin
        len = '0;
      end else if (r < 70) begin
        len = LEN_W'($urandom_range(4, 1));
      end else if (r < 88) begin
        len = LEN_W'($urandom_range(31, 5));
      end else if (r < 95) begin
        len = LEN_W'(PATTERN_BYTES);
      end else begin
        len = LEN_W'($urandom_range(63, 33));
      end
      fold = 1'($urandom_range(1));
      noise = ($urandom_range(9) == 0);
      for (k = 0; k < PATTERN_BYTES; k++) begin
        pb[k] = noise ? 8'($urandom_range(255)) : pick_byte();
        w[k/8][8*(k%8) +: 8] = pb[k];
      end
      set_search(w[0], w[1], w[2], w[3], len, fold);
      ntexts = $urandom_range(6, 3);
      for (t = 0; t < ntexts; t++) begin
        noise = ($urandom_range(99) < 15);
        if (noise) begin
          n = $urandom_range(70, 1);
          for (k = 0; k < n; k++) begin
            push_byte(8'($urandom_range(255)), k == n - 1);
          end
        end else begin
          n = $urandom_range(6, 0);
          for (k = 0; k < n; k++) begin
            push_byte(pick_byte(), 1'b0);
          end
          if (len >= 1 && len <= PATTERN_BYTES && $urandom_range(3) != 0) begin
            for (k = 0; k < int'(len); k++) begin
              push_byte(maybe_flip(pb[k]), 1'b0);
            end
            n += int'(len);
          end
          r = $urandom_range(6, 1);
          for (k = 0; k < r; k++) begin
            push_byte(pick_byte(), k == r - 1);
          end
          n += r;
        end
        random_items += n;
      end
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
